>>> rtl/rtn_pkg.sv
// rtn_pkg: shared constants, types and the multiply micro-program for the
// ray/triangle nearest-hit block. No dependencies; every rtl file uses it.
package rtn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int BARY_BITS = 16;
  localparam int ID_BITS   = 16;
  localparam int COORD_W   = 32;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int OPND_W    = 35;
  localparam int SPLIT     = OPND_W - 1;
  localparam int WIDE_W    = 2 * SPLIT;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int ACC_W     = 104;
  localparam int DIST_W    = 31;
  localparam int BARY_W    = BARY_BITS + 1;
  localparam int EPS_W     = 31;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int MOP_LEN   = 36;
  localparam int STEP_W    = 6;
  localparam int CNT_W     = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [2:0] {
    REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
    REG_DIR_X, REG_DIR_Y, REG_DIR_Z, REG_EPSILON
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic signed [COORD_W-1:0] org_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic        [EPS_W-1:0]   eps;
  } ray_cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
  } tri_vtx_t;

  typedef enum logic [4:0] {
    SRC_DIR_X, SRC_DIR_Y, SRC_DIR_Z,
    SRC_E1_X, SRC_E1_Y, SRC_E1_Z,
    SRC_E2_X, SRC_E2_Y, SRC_E2_Z,
    SRC_TV_X, SRC_TV_Y, SRC_TV_Z,
    SRC_PV_X, SRC_PV_Y, SRC_PV_Z,
    SRC_QV_X, SRC_QV_Y, SRC_QV_Z
  } src_t;

  typedef enum logic [1:0] {PART_FULL, PART_LO, PART_HI} part_t;

  typedef enum logic [3:0] {
    DST_PV_X, DST_PV_Y, DST_PV_Z,
    DST_QV_X, DST_QV_Y, DST_QV_Z,
    DST_DET, DST_NU, DST_NV, DST_NT
  } dst_t;

  typedef struct packed {
    src_t  a;
    src_t  b;
    part_t part;
    logic  sub;
    logic  first;
    logic  last;
    dst_t  dst;
  } mop_t;

  function automatic mop_t mk(input src_t a, input src_t b, input part_t p,
                              input logic sub, input logic first,
                              input logic last, input dst_t dst);
    mop_t m;
    m.a = a;
    m.b = b;
    m.part = p;
    m.sub = sub;
    m.first = first;
    m.last = last;
    m.dst = dst;
    return m;
  endfunction

  // cross products first, then dot products against the stored crosses
  function automatic mop_t mop_rom(input logic [STEP_W-1:0] step);
    mop_t m;
    case (step)
      6'd0:  m = mk(SRC_DIR_Y, SRC_E2_Z, PART_FULL, 1'b0, 1'b1, 1'b0, DST_PV_X);
      6'd1:  m = mk(SRC_DIR_Z, SRC_E2_Y, PART_FULL, 1'b1, 1'b0, 1'b1, DST_PV_X);
      6'd2:  m = mk(SRC_DIR_Z, SRC_E2_X, PART_FULL, 1'b0, 1'b1, 1'b0, DST_PV_Y);
      6'd3:  m = mk(SRC_DIR_X, SRC_E2_Z, PART_FULL, 1'b1, 1'b0, 1'b1, DST_PV_Y);
      6'd4:  m = mk(SRC_DIR_X, SRC_E2_Y, PART_FULL, 1'b0, 1'b1, 1'b0, DST_PV_Z);
      6'd5:  m = mk(SRC_DIR_Y, SRC_E2_X, PART_FULL, 1'b1, 1'b0, 1'b1, DST_PV_Z);
      6'd6:  m = mk(SRC_TV_Y, SRC_E1_Z, PART_FULL, 1'b0, 1'b1, 1'b0, DST_QV_X);
      6'd7:  m = mk(SRC_TV_Z, SRC_E1_Y, PART_FULL, 1'b1, 1'b0, 1'b1, DST_QV_X);
      6'd8:  m = mk(SRC_TV_Z, SRC_E1_X, PART_FULL, 1'b0, 1'b1, 1'b0, DST_QV_Y);
      6'd9:  m = mk(SRC_TV_X, SRC_E1_Z, PART_FULL, 1'b1, 1'b0, 1'b1, DST_QV_Y);
      6'd10: m = mk(SRC_TV_X, SRC_E1_Y, PART_FULL, 1'b0, 1'b1, 1'b0, DST_QV_Z);
      6'd11: m = mk(SRC_TV_Y, SRC_E1_X, PART_FULL, 1'b1, 1'b0, 1'b1, DST_QV_Z);
      6'd12: m = mk(SRC_E1_X, SRC_PV_X, PART_LO, 1'b0, 1'b1, 1'b0, DST_DET);
      6'd13: m = mk(SRC_E1_X, SRC_PV_X, PART_HI, 1'b0, 1'b0, 1'b0, DST_DET);
      6'd14: m = mk(SRC_E1_Y, SRC_PV_Y, PART_LO, 1'b0, 1'b0, 1'b0, DST_DET);
      6'd15: m = mk(SRC_E1_Y, SRC_PV_Y, PART_HI, 1'b0, 1'b0, 1'b0, DST_DET);
      6'd16: m = mk(SRC_E1_Z, SRC_PV_Z, PART_LO, 1'b0, 1'b0, 1'b0, DST_DET);
      6'd17: m = mk(SRC_E1_Z, SRC_PV_Z, PART_HI, 1'b0, 1'b0, 1'b1, DST_DET);
      6'd18: m = mk(SRC_TV_X, SRC_PV_X, PART_LO, 1'b0, 1'b1, 1'b0, DST_NU);
      6'd19: m = mk(SRC_TV_X, SRC_PV_X, PART_HI, 1'b0, 1'b0, 1'b0, DST_NU);
      6'd20: m = mk(SRC_TV_Y, SRC_PV_Y, PART_LO, 1'b0, 1'b0, 1'b0, DST_NU);
      6'd21: m = mk(SRC_TV_Y, SRC_PV_Y, PART_HI, 1'b0, 1'b0, 1'b0, DST_NU);
      6'd22: m = mk(SRC_TV_Z, SRC_PV_Z, PART_LO, 1'b0, 1'b0, 1'b0, DST_NU);
      6'd23: m = mk(SRC_TV_Z, SRC_PV_Z, PART_HI, 1'b0, 1'b0, 1'b1, DST_NU);
      6'd24: m = mk(SRC_DIR_X, SRC_QV_X, PART_LO, 1'b0, 1'b1, 1'b0, DST_NV);
      6'd25: m = mk(SRC_DIR_X, SRC_QV_X, PART_HI, 1'b0, 1'b0, 1'b0, DST_NV);
      6'd26: m = mk(SRC_DIR_Y, SRC_QV_Y, PART_LO, 1'b0, 1'b0, 1'b0, DST_NV);
      6'd27: m = mk(SRC_DIR_Y, SRC_QV_Y, PART_HI, 1'b0, 1'b0, 1'b0, DST_NV);
      6'd28: m = mk(SRC_DIR_Z, SRC_QV_Z, PART_LO, 1'b0, 1'b0, 1'b0, DST_NV);
      6'd29: m = mk(SRC_DIR_Z, SRC_QV_Z, PART_HI, 1'b0, 1'b0, 1'b1, DST_NV);
      6'd30: m = mk(SRC_E2_X, SRC_QV_X, PART_LO, 1'b0, 1'b1, 1'b0, DST_NT);
      6'd31: m = mk(SRC_E2_X, SRC_QV_X, PART_HI, 1'b0, 1'b0, 1'b0, DST_NT);
      6'd32: m = mk(SRC_E2_Y, SRC_QV_Y, PART_LO, 1'b0, 1'b0, 1'b0, DST_NT);
      6'd33: m = mk(SRC_E2_Y, SRC_QV_Y, PART_HI, 1'b0, 1'b0, 1'b0, DST_NT);
      6'd34: m = mk(SRC_E2_Z, SRC_QV_Z, PART_LO, 1'b0, 1'b0, 1'b0, DST_NT);
      6'd35: m = mk(SRC_E2_Z, SRC_QV_Z, PART_HI, 1'b0, 1'b0, 1'b1, DST_NT);
      default: m = mk(SRC_DIR_X, SRC_DIR_X, PART_FULL, 1'b0, 1'b0, 1'b0, DST_PV_X);
    endcase
    return m;
  endfunction

endpackage

>>> rtl/rtn_in_if.sv
// rtn_in_if: triangle input channel, valid/ready with vertex payload
// depends on rtn_pkg for widths
interface rtn_in_if;
  logic valid;
  logic ready;
  logic signed [rtn_pkg::COORD_W-1:0] v0_x;
  logic signed [rtn_pkg::COORD_W-1:0] v0_y;
  logic signed [rtn_pkg::COORD_W-1:0] v0_z;
  logic signed [rtn_pkg::COORD_W-1:0] v1_x;
  logic signed [rtn_pkg::COORD_W-1:0] v1_y;
  logic signed [rtn_pkg::COORD_W-1:0] v1_z;
  logic signed [rtn_pkg::COORD_W-1:0] v2_x;
  logic signed [rtn_pkg::COORD_W-1:0] v2_y;
  logic signed [rtn_pkg::COORD_W-1:0] v2_z;
  logic [rtn_pkg::ID_BITS-1:0] triangle_id;
  logic new_ray;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, triangle_id, new_ray, input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, triangle_id, new_ray, output ready);
endinterface

>>> rtl/rtn_out_if.sv
// rtn_out_if: hit result channel, valid/ready with hit payload
// depends on rtn_pkg for widths
interface rtn_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [rtn_pkg::DIST_W-1:0] hit_distance;
  logic [rtn_pkg::BARY_W-1:0] bary_u;
  logic [rtn_pkg::BARY_W-1:0] bary_v;
  logic is_nearest;
  logic [rtn_pkg::DIST_W-1:0] nearest_distance;
  logic [rtn_pkg::ID_BITS-1:0] nearest_id;

  modport source (output valid, hit, hit_distance, bary_u, bary_v, is_nearest,
                  nearest_distance, nearest_id, input ready);
  modport sink (input valid, hit, hit_distance, bary_u, bary_v, is_nearest,
                nearest_distance, nearest_id, output ready);
endinterface

>>> rtl/rtn_regs.sv
// rtn_regs: apb-style ray configuration registers
// depends on rtn_pkg
module rtn_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rtn_pkg::CFG_AW-1:0]  paddr,
  input  logic [rtn_pkg::CFG_DW-1:0]  pwdata,
  output logic [rtn_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output rtn_pkg::ray_cfg_t           cfg
);
  rtn_pkg::ray_cfg_t cfg_r;
  rtn_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = rtn_pkg::reg_idx_t'(paddr[rtn_pkg::CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.org_x <= '0;
      cfg_r.org_y <= '0;
      cfg_r.org_z <= '0;
      cfg_r.dir_x <= '0;
      cfg_r.dir_y <= '0;
      cfg_r.dir_z <= 32'sd65536;
      cfg_r.eps   <= 31'd1;
    end else if (wr_en) begin
      unique case (idx)
        rtn_pkg::REG_ORIGIN_X: cfg_r.org_x <= pwdata;
        rtn_pkg::REG_ORIGIN_Y: cfg_r.org_y <= pwdata;
        rtn_pkg::REG_ORIGIN_Z: cfg_r.org_z <= pwdata;
        rtn_pkg::REG_DIR_X:    cfg_r.dir_x <= pwdata;
        rtn_pkg::REG_DIR_Y:    cfg_r.dir_y <= pwdata;
        rtn_pkg::REG_DIR_Z:    cfg_r.dir_z <= pwdata;
        rtn_pkg::REG_EPSILON:  cfg_r.eps   <= pwdata[rtn_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rtn_pkg::REG_ORIGIN_X: prdata = cfg_r.org_x;
      rtn_pkg::REG_ORIGIN_Y: prdata = cfg_r.org_y;
      rtn_pkg::REG_ORIGIN_Z: prdata = cfg_r.org_z;
      rtn_pkg::REG_DIR_X:    prdata = cfg_r.dir_x;
      rtn_pkg::REG_DIR_Y:    prdata = cfg_r.dir_y;
      rtn_pkg::REG_DIR_Z:    prdata = cfg_r.dir_z;
      rtn_pkg::REG_EPSILON:  prdata = {1'b0, cfg_r.eps};
      default:               prdata = '0;
    endcase
  end
endmodule

>>> rtl/rtn_mac.sv
// rtn_mac: one shared 35x35 signed multiplier with accumulator, stepped by
// the micro-program in rtn_pkg; yields det and the u, v, t numerators
module rtn_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  rtn_pkg::tri_vtx_t                 vtx,
  input  rtn_pkg::ray_cfg_t                 cfg,
  output logic                              done,
  output logic signed [rtn_pkg::ACC_W-1:0]  det,
  output logic signed [rtn_pkg::ACC_W-1:0]  nu,
  output logic signed [rtn_pkg::ACC_W-1:0]  nv,
  output logic signed [rtn_pkg::ACC_W-1:0]  nt
);
  localparam int EW = rtn_pkg::EDGE_W;
  localparam int WW = rtn_pkg::WIDE_W;
  localparam int AW = rtn_pkg::ACC_W;
  localparam int OW = rtn_pkg::OPND_W;
  localparam int SP = rtn_pkg::SPLIT;

  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] tv_r [3];
  logic signed [WW-1:0] pv_r [3];
  logic signed [WW-1:0] qv_r [3];
  logic signed [AW-1:0] det_r, nu_r, nv_r, nt_r, acc_r, acc_nxt, addend, base;
  logic signed [WW-1:0] srcv [18];
  logic signed [WW-1:0] a_full, b_full;
  logic signed [OW-1:0] a_op, b_op;
  logic signed [rtn_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [rtn_pkg::STEP_W-1:0] step_r;
  logic busy_r, st1_vld_r, done_r;
  rtn_pkg::mop_t op, ctl_r;

  assign srcv[0]  = WW'($signed(cfg.dir_x));
  assign srcv[1]  = WW'($signed(cfg.dir_y));
  assign srcv[2]  = WW'($signed(cfg.dir_z));
  assign srcv[3]  = WW'(e1_r[0]);
  assign srcv[4]  = WW'(e1_r[1]);
  assign srcv[5]  = WW'(e1_r[2]);
  assign srcv[6]  = WW'(e2_r[0]);
  assign srcv[7]  = WW'(e2_r[1]);
  assign srcv[8]  = WW'(e2_r[2]);
  assign srcv[9]  = WW'(tv_r[0]);
  assign srcv[10] = WW'(tv_r[1]);
  assign srcv[11] = WW'(tv_r[2]);
  assign srcv[12] = pv_r[0];
  assign srcv[13] = pv_r[1];
  assign srcv[14] = pv_r[2];
  assign srcv[15] = qv_r[0];
  assign srcv[16] = qv_r[1];
  assign srcv[17] = qv_r[2];

  assign op     = rtn_pkg::mop_rom(step_r);
  assign a_full = srcv[op.a];
  assign b_full = srcv[op.b];
  assign a_op   = a_full[OW-1:0];

  // wide operands go through in two halves: unsigned low, signed high
  always_comb begin
    case (op.part)
      rtn_pkg::PART_FULL: b_op = b_full[OW-1:0];
      rtn_pkg::PART_LO:   b_op = {1'b0, b_full[SP-1:0]};
      rtn_pkg::PART_HI:   b_op = {b_full[WW-1], b_full[WW-1:SP]};
      default:            b_op = '0;
    endcase
  end

  assign prod_nxt = a_op * b_op;

  always_comb begin
    addend = (ctl_r.part == rtn_pkg::PART_HI) ? (AW'(prod_r) <<< SP) : AW'(prod_r);
    base   = ctl_r.first ? '0 : acc_r;
    acc_nxt = ctl_r.sub ? base - addend : base + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      step_r    <= '0;
      st1_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      done_r    <= st1_vld_r && ctl_r.last && (ctl_r.dst == rtn_pkg::DST_NT);
      st1_vld_r <= busy_r;
      if (load) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == rtn_pkg::STEP_W'(rtn_pkg::MOP_LEN - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e1_r[0] <= EW'(vtx.v1_x) - EW'(vtx.v0_x);
      e1_r[1] <= EW'(vtx.v1_y) - EW'(vtx.v0_y);
      e1_r[2] <= EW'(vtx.v1_z) - EW'(vtx.v0_z);
      e2_r[0] <= EW'(vtx.v2_x) - EW'(vtx.v0_x);
      e2_r[1] <= EW'(vtx.v2_y) - EW'(vtx.v0_y);
      e2_r[2] <= EW'(vtx.v2_z) - EW'(vtx.v0_z);
      tv_r[0] <= EW'($signed(cfg.org_x)) - EW'(vtx.v0_x);
      tv_r[1] <= EW'($signed(cfg.org_y)) - EW'(vtx.v0_y);
      tv_r[2] <= EW'($signed(cfg.org_z)) - EW'(vtx.v0_z);
    end
    prod_r <= prod_nxt;
    ctl_r  <= op;
    if (st1_vld_r) begin
      acc_r <= acc_nxt;
      if (ctl_r.last) begin
        case (ctl_r.dst)
          rtn_pkg::DST_PV_X: pv_r[0] <= acc_nxt[WW-1:0];
          rtn_pkg::DST_PV_Y: pv_r[1] <= acc_nxt[WW-1:0];
          rtn_pkg::DST_PV_Z: pv_r[2] <= acc_nxt[WW-1:0];
          rtn_pkg::DST_QV_X: qv_r[0] <= acc_nxt[WW-1:0];
          rtn_pkg::DST_QV_Y: qv_r[1] <= acc_nxt[WW-1:0];
          rtn_pkg::DST_QV_Z: qv_r[2] <= acc_nxt[WW-1:0];
          rtn_pkg::DST_DET:  det_r   <= acc_nxt;
          rtn_pkg::DST_NU:   nu_r    <= acc_nxt;
          rtn_pkg::DST_NV:   nv_r    <= acc_nxt;
          rtn_pkg::DST_NT:   nt_r    <= acc_nxt;
          default: ;
        endcase
      end
    end
  end

  assign done = done_r;
  assign det  = det_r;
  assign nu   = nu_r;
  assign nv   = nv_r;
  assign nt   = nt_r;
endmodule

>>> rtl/rtn_div.sv
// rtn_div: radix-2 restoring divider, one quotient bit a cycle, for
// floor((x << FRAC_BITS) / d) with a 31-bit (distance, saturating) or 17-bit (bary) result
module rtn_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             is_dist,
  input  logic [rtn_pkg::ACC_W-1:0]        x,
  input  logic [rtn_pkg::ACC_W-1:0]        d,
  output logic                             done,
  output logic [rtn_pkg::DIST_W-1:0]       q
);
  localparam int AW = rtn_pkg::ACC_W;
  localparam int NW = AW + rtn_pkg::FRAC_BITS;
  localparam int DW = rtn_pkg::DIST_W;
  localparam int BW = rtn_pkg::BARY_W;

  logic [NW-1:0] num;
  logic [AW-1:0] r0_dist, r0_bary, rem_r, d_r;
  logic [DW-1:0] lb_r, q_r, lb_dist, lb_bary;
  logic [AW:0]   trial, diff;
  logic [rtn_pkg::CNT_W-1:0] cnt_r;
  logic busy_r, done_r, ge;

  assign num     = {x, {rtn_pkg::FRAC_BITS{1'b0}}};
  assign r0_dist = AW'(num >> DW);
  assign r0_bary = AW'(num >> BW);
  assign lb_dist = num[DW-1:0];
  assign lb_bary = {num[BW-1:0], {(DW - BW){1'b0}}};
  assign trial   = {rem_r, lb_r[DW-1]};
  assign diff    = trial - {1'b0, d_r};
  assign ge      = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        d_r <= d;
        if (is_dist && (r0_dist >= d)) begin
          // quotient would not fit: saturate
          q_r    <= rtn_pkg::DIST_MAX;
          done_r <= 1'b1;
        end else begin
          q_r    <= '0;
          done_r <= 1'b0;
          busy_r <= 1'b1;
          rem_r  <= is_dist ? r0_dist : r0_bary;
          lb_r   <= is_dist ? lb_dist : lb_bary;
          cnt_r  <= is_dist ? rtn_pkg::CNT_W'(DW) : rtn_pkg::CNT_W'(BW);
        end
      end else if (busy_r) begin
        rem_r  <= ge ? diff[AW-1:0] : trial[AW-1:0];
        q_r    <= {q_r[DW-2:0], ge};
        lb_r   <= {lb_r[DW-2:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == rtn_pkg::CNT_W'(1));
        if (cnt_r == rtn_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;
endmodule

>>> rtl/ray_triangle_nearest_hit_top.sv
// ray_triangle_nearest_hit_top: nearest-hit ray/triangle tester, top level
// depends on rtn_pkg, rtn_in_if, rtn_out_if, rtn_regs, rtn_mac, rtn_div
//
// usage
//   the ray (origin, direction, parallel epsilon) sits in apb-style registers
//   at byte address 4*i; write them only while the block is idle
//   each in_if transaction carries one triangle; new_ray clears the nearest
//   hit (distance all ones, id 0) before that triangle is tested
//   each triangle yields exactly one out_if transaction: hit flag, distance t,
//   barycentric u and v, whether it became the nearest, and the nearest so far
// flow
//   in_if.ready is high only in the idle state; one triangle is in flight
//   the shared multiplier runs 36 micro-steps through its product and
//   accumulator registers, then S_NORM fixes signs, S_CHECK tests acceptance
//   a miss goes straight to the result; a hit adds the shared divider for
//   t (31-bit, saturating), then u and v (17-bit each)
//   the next triangle is taken while the last result still waits on out_if
// reset and stall
//   rst_n is synchronous active low; clears control, config and nearest hit
//   if the receiver stalls, the finished result holds until the previous one
//   has been taken, and the block stays busy until then
module ray_triangle_nearest_hit_top (
  input  logic                       clk,
  input  logic                       rst_n,
  rtn_in_if.sink                     in_if,
  rtn_out_if.source                  out_if,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rtn_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rtn_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rtn_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  localparam int AW = rtn_pkg::ACC_W;
  localparam int DW = rtn_pkg::DIST_W;
  localparam int BW = rtn_pkg::BARY_W;
  localparam int EW = rtn_pkg::EPS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_NORM, S_CHECK, S_DIV_T, S_DIV_U, S_DIV_V, S_FIN
  } state_t;

  state_t state_r;
  rtn_pkg::ray_cfg_t cfg;
  rtn_pkg::tri_vtx_t vtx;

  logic in_acc, out_free;
  logic mac_done;
  logic signed [AW-1:0] mac_det, mac_nu, mac_nv, mac_nt;
  logic signed [AW-1:0] det_r, nu_r, nv_r, nt_r;
  logic signed [AW:0]   uv_sum;
  logic pass;

  logic div_start, div_is_dist, div_done;
  logic [AW-1:0] div_x;
  logic [DW-1:0] div_q;

  logic [rtn_pkg::ID_BITS-1:0] tri_id_r, best_id_r;
  logic [DW-1:0] best_dist_r, dist_r;
  logic [BW-1:0] bu_r, bv_r;
  logic hit_r, closer;

  logic out_valid_r, out_hit_r, out_near_r;
  logic [DW-1:0] out_dist_r, out_ndist_r;
  logic [BW-1:0] out_bu_r, out_bv_r;
  logic [rtn_pkg::ID_BITS-1:0] out_nid_r;

  // configuration registers
  rtn_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_if.ready;

  assign vtx.v0_x = in_if.v0_x;
  assign vtx.v0_y = in_if.v0_y;
  assign vtx.v0_z = in_if.v0_z;
  assign vtx.v1_x = in_if.v1_x;
  assign vtx.v1_y = in_if.v1_y;
  assign vtx.v1_z = in_if.v1_z;
  assign vtx.v2_x = in_if.v2_x;
  assign vtx.v2_y = in_if.v2_y;
  assign vtx.v2_z = in_if.v2_z;

  // cross and dot products on the shared multiplier
  rtn_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_acc),
    .vtx   (vtx),
    .cfg   (cfg),
    .done  (mac_done),
    .det   (mac_det),
    .nu    (mac_nu),
    .nv    (mac_nv),
    .nt    (mac_nt)
  );

  // acceptance on numerators after det is made positive
  assign uv_sum = (AW + 1)'(nu_r) + (AW + 1)'(nv_r);
  assign pass = (det_r != '0) &&
                !((det_r[AW-1:EW] == '0) && (det_r[EW-1:0] < cfg.eps)) &&
                !nu_r[AW-1] && !(nu_r > det_r) &&
                !nv_r[AW-1] && !(uv_sum > (AW + 1)'(det_r)) &&
                !nt_r[AW-1] && (nt_r != '0);

  // divider sequencing: t, then u, then v, all over det
  always_comb begin
    div_start   = 1'b0;
    div_is_dist = 1'b0;
    div_x       = nt_r;
    case (state_r)
      S_CHECK: begin
        div_start   = pass;
        div_is_dist = 1'b1;
        div_x       = nt_r;
      end
      S_DIV_T: begin
        div_start = div_done;
        div_x     = nu_r;
      end
      S_DIV_U: begin
        div_start = div_done;
        div_x     = nv_r;
      end
      default: ;
    endcase
  end

  rtn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .is_dist (div_is_dist),
    .x       (div_x),
    .d       (det_r),
    .done    (div_done),
    .q       (div_q)
  );

  // strict compare keeps the earlier triangle on equal distance
  assign closer = hit_r && (dist_r < best_dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      best_dist_r <= rtn_pkg::DIST_MAX;
      best_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_FIN a free output register is refilled below instead
      if (out_valid_r && out_if.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            tri_id_r <= in_if.triangle_id;
            if (in_if.new_ray) begin
              best_dist_r <= rtn_pkg::DIST_MAX;
              best_id_r   <= '0;
            end
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (mac_done) begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // flip signs so det is positive
          det_r   <= mac_det[AW-1] ? -mac_det : mac_det;
          nu_r    <= mac_det[AW-1] ? -mac_nu  : mac_nu;
          nv_r    <= mac_det[AW-1] ? -mac_nv  : mac_nv;
          nt_r    <= mac_det[AW-1] ? -mac_nt  : mac_nt;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          hit_r   <= pass;
          dist_r  <= '0;
          bu_r    <= '0;
          bv_r    <= '0;
          state_r <= pass ? S_DIV_T : S_FIN;
        end
        S_DIV_T: begin
          if (div_done) begin
            dist_r  <= div_q;
            state_r <= S_DIV_U;
          end
        end
        S_DIV_U: begin
          if (div_done) begin
            bu_r    <= div_q[BW-1:0];
            state_r <= S_DIV_V;
          end
        end
        S_DIV_V: begin
          if (div_done) begin
            bv_r    <= div_q[BW-1:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // hand the result over once the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= hit_r;
            out_dist_r  <= dist_r;
            out_bu_r    <= bu_r;
            out_bv_r    <= bv_r;
            out_near_r  <= closer;
            out_ndist_r <= closer ? dist_r : best_dist_r;
            out_nid_r   <= closer ? tri_id_r : best_id_r;
            if (closer) begin
              best_dist_r <= dist_r;
              best_id_r   <= tri_id_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.hit              = out_hit_r;
  assign out_if.hit_distance     = out_dist_r;
  assign out_if.bary_u           = out_bu_r;
  assign out_if.bary_v           = out_bv_r;
  assign out_if.is_nearest       = out_near_r;
  assign out_if.nearest_distance = out_ndist_r;
  assign out_if.nearest_id       = out_nid_r;
endmodule

>>> rtl/rtn_chk.sv
// rtn_chk: port-level checks for the nearest-hit block, bound to the top
// depends on rtn_pkg and ray_triangle_nearest_hit_top
module rtn_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [rtn_pkg::DIST_W-1:0]  out_hit_distance,
  input logic [rtn_pkg::BARY_W-1:0]  out_bary_u,
  input logic [rtn_pkg::BARY_W-1:0]  out_bary_v,
  input logic                        out_is_nearest,
  input logic [rtn_pkg::DIST_W-1:0]  out_nearest_distance
);
  // one triangle in flight: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transaction");

  // stalled result stays valid and its distance holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit_distance)))
    else $error("stalled result changed");

  // misses carry zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_distance == '0 && out_bary_u == '0 &&
                                 out_bary_v == '0 && !out_is_nearest))
    else $error("miss with nonzero fields");

  // a new nearest is this hit
  a_nearest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_nearest) |-> (out_hit &&
                                       out_nearest_distance == out_hit_distance))
    else $error("nearest does not match hit");

  // u plus v stays inside the triangle
  a_bary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((rtn_pkg::BARY_W + 1)'(out_bary_u) + (rtn_pkg::BARY_W + 1)'(out_bary_v)
                   <= (rtn_pkg::BARY_W + 1)'(1 << rtn_pkg::BARY_BITS)))
    else $error("barycentrics out of range");
endmodule

bind ray_triangle_nearest_hit_top rtn_chk u_rtn_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_if.valid),
  .in_ready             (in_if.ready),
  .out_valid            (out_if.valid),
  .out_ready            (out_if.ready),
  .out_hit              (out_if.hit),
  .out_hit_distance     (out_if.hit_distance),
  .out_bary_u           (out_if.bary_u),
  .out_bary_v           (out_if.bary_v),
  .out_is_nearest       (out_if.is_nearest),
  .out_nearest_distance (out_if.nearest_distance)
);
